>>> sv/hte_pkg.sv
// hte_pkg: shared types, pattern tables and constants for the html text extractor
// no dependencies

package hte_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CapW   = 21;
  localparam int unsigned CountW = 20;
  localparam int unsigned NumPat = 4;
  localparam int unsigned PatMax = 9;
  localparam int unsigned ProgW  = 4;

  localparam logic [ByteW-1:0] CharNul = 8'h00;
  localparam logic [ByteW-1:0] CharLt  = 8'h3C;
  localparam logic [ByteW-1:0] CharGt  = 8'h3E;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] LimitRst = CountW'(99999);

  // pattern slots
  localparam int unsigned PatScriptOpen  = 0;
  localparam int unsigned PatScriptClose = 1;
  localparam int unsigned PatStyleOpen   = 2;
  localparam int unsigned PatStyleClose  = 3;

  // byte 0 of each pattern sits in the lowest lane
  localparam logic [NumPat-1:0][PatMax-1:0][ByteW-1:0] PatText = {
    {8'h00, ">", "e", "l", "y", "t", "s", "/", "<"},
    {8'h00, 8'h00, 8'h00, "e", "l", "y", "t", "s", "<"},
    {">", "t", "p", "i", "r", "c", "s", "/", "<"},
    {8'h00, 8'h00, "t", "p", "i", "r", "c", "s", "<"}
  };

  localparam logic [NumPat-1:0][ProgW-1:0] PatLen = {4'd8, 4'd6, 4'd9, 4'd7};

  typedef logic [NumPat-1:0][ProgW-1:0] prog_t;

  typedef struct packed {
    logic [ByteW-1:0] html_byte;
    logic             doc_last;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             has_byte;
    logic             end_of_text;
  } out_item_t;

  typedef struct packed {
    logic script_open;
    logic script_close;
    logic style_open;
    logic style_close;
  } match_hits_t;

  function automatic logic [ByteW-1:0] pat_char(input logic [1:0] k,
                                                input logic [ProgW-1:0] i);
    logic [ByteW-1:0] c;
    c = CharNul;
    if (i < ProgW'(PatMax)) begin
      c = PatText[k][i];
    end
    return c;
  endfunction

endpackage

>>> sv/html_text_extractor_top.sv
// html_text_extractor_top: request register, filter core, result register, capacity register
// depends on hte_pkg and hte_core

// Takes one HTML byte per cycle and gives a result for each visible text byte under the
// emit limit and one closing result per document (zero byte or doc_last). Sustained rate
// is one request per cycle while in_stall_o is low, set by the per-byte state update in
// the core; a byte passes the request register and then the result register. A stalled
// result blocks only a request that itself produces a result. text_capacity is written
// through cfg_we_i/cfg_wdata_i and is held as a precomputed emit limit.
module html_text_extractor_top import hte_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  logic              in_valid_q;
  in_item_t          in_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic [CountW-1:0] limit_q, limit_d;
  logic [CapW-1:0]   cap_m1;
  logic              res_valid, fire, take;
  out_item_t         res;

  hte_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_q),
    .step_i      (fire),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign fire       = in_valid_q && !(res_valid && out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  // limit is capacity less one, saturated to the count range
  always_comb begin
    cap_m1 = cfg_wdata_i - CapW'(1);
    if (cfg_wdata_i == '0) begin
      limit_d = '0;
    end else if (cap_m1[CapW-1]) begin
      limit_d = CountMax;
    end else begin
      limit_d = cap_m1[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
    end else if (cfg_we_i) begin
      limit_q <= limit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_valid |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_byte_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.has_byte |-> out_q.text_byte != CharNul)
    else $error("emitted text byte is zero");

  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.has_byte |-> out_q.end_of_text && out_q.text_byte == CharNul)
    else $error("result without text does not close the document");

  a_zero_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_q.html_byte == CharNul |-> res_valid && res.end_of_text)
    else $error("zero byte did not close the document");
`endif

endmodule

>>> sv/hte_match.sv
// hte_match: incremental tag name matchers, one per pattern
// depends on hte_pkg

module hte_match import hte_pkg::*; (
  input  prog_t            prog_i,
  input  logic [ByteW-1:0] byte_i,
  output prog_t            prog_o,
  output match_hits_t      hits_o
);

  logic [NumPat-1:0] hit;

  always_comb begin
    for (int k = 0; k < NumPat; k++) begin
      logic [ProgW-1:0] p;
      p = prog_i[k];
      if (byte_i == CharLt) begin
        p = ProgW'(1);
      end else if (p != '0 && p < PatLen[k] && pat_char(2'(k), p) == byte_i) begin
        p = p + ProgW'(1);
      end else begin
        p = '0;
      end
      hit[k] = (p >= PatLen[k]);
      prog_o[k] = hit[k] ? '0 : p;
    end
  end

  assign hits_o.script_open  = hit[PatScriptOpen];
  assign hits_o.script_close = hit[PatScriptClose];
  assign hits_o.style_open   = hit[PatStyleOpen];
  assign hits_o.style_close  = hit[PatStyleClose];

endmodule

>>> sv/hte_core.sv
// hte_core: per-document state, emit decision and result formation
// depends on hte_pkg and hte_match

module hte_core import hte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_item_t          item_i,
  input  logic              step_i,
  input  logic [CountW-1:0] limit_i,
  output logic              res_valid_o,
  output out_item_t         res_o
);

  logic              tag_q, tag_d;
  logic              script_q, script_d;
  logic              style_q, style_d;
  prog_t             prog_q, prog_d, prog_next;
  logic [CountW-1:0] count_q, count_d;
  match_hits_t       hits;
  logic              is_zero, active, emit;

  hte_match u_match (
    .prog_i (prog_q),
    .byte_i (item_i.html_byte),
    .prog_o (prog_next),
    .hits_o (hits)
  );

  always_comb begin
    is_zero  = (item_i.html_byte == CharNul);
    active   = (count_q < limit_i);
    emit     = 1'b0;
    tag_d    = tag_q;
    script_d = script_q;
    style_d  = style_q;
    prog_d   = prog_q;
    count_d  = count_q;
    if (!is_zero && active) begin
      prog_d = prog_next;
      if (hits.script_open) begin
        script_d = 1'b1;
      end else if (hits.script_close) begin
        script_d = 1'b0;
      end
      if (hits.style_open) begin
        style_d = 1'b1;
      end else if (hits.style_close) begin
        style_d = 1'b0;
      end
      if (item_i.html_byte == CharLt) begin
        tag_d = 1'b1;
      end else if (item_i.html_byte == CharGt) begin
        tag_d = 1'b0;
      end else if (!tag_q && !script_d && !style_d) begin
        emit    = 1'b1;
        count_d = count_q + CountW'(1);
      end
    end
    if (is_zero || item_i.doc_last) begin
      tag_d    = 1'b0;
      script_d = 1'b0;
      style_d  = 1'b0;
      prog_d   = '0;
      count_d  = '0;
    end
    res_valid_o       = emit || is_zero || item_i.doc_last;
    res_o.text_byte   = emit ? item_i.html_byte : CharNul;
    res_o.has_byte    = emit;
    res_o.end_of_text = is_zero || item_i.doc_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q    <= 1'b0;
      script_q <= 1'b0;
      style_q  <= 1'b0;
      prog_q   <= '0;
      count_q  <= '0;
    end else if (step_i) begin
      tag_q    <= tag_d;
      script_q <= script_d;
      style_q  <= style_d;
      prog_q   <= prog_d;
      count_q  <= count_d;
    end
  end

endmodule
